### src/fla_pkg.sv
// Package for the free-list pool allocator.
// Holds field widths, reset constants, the controller state type and the
// command and status structs shared by the controller and the datapath.
package fla_pkg;

	// Field widths fixed by the interface.
	localparam int IDX_W = 11;
	localparam int CNT_W = 12;

	// Default pool size and configuration reset value.
	localparam int POOL_DEPTH_DEF = 2048;
	localparam logic [CNT_W-1:0] WARN_RESET = 12'd1548;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Item kinds.
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC
	} fla_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_wr;  // write one link entry of the clearing pass
		logic capture;  // latch the accepted item
		logic exec;     // commit the item and load the result registers
	} fla_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;  // the clearing pass writes its last entry
	} fla_sts_t;

endpackage

### src/free_list_pool_allocator.sv
// Free-list pool allocator: LIFO free list of pool indices in a link memory.
// An accepted item is committed in the execute state and its result is
// registered; busy holds off a new item until that state is left.
// After reset, busy stays high while the link memory is initialized;
// configuration writes are taken during that time.
// The result is shown for one cycle on done; the receiver cannot stall.
module free_list_pool_allocator
	import fla_pkg::*;
#(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// Item interface.
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic [IDX_W-1:0] release_index,
	output logic             done,
	output logic [IDX_W-1:0] granted_index,
	output logic             alloc_ok,
	output logic             stop_warning,
	output logic [CNT_W-1:0] used_count,
	// Configuration port.
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	fla_cmd_t cmd;
	fla_sts_t sts;
	logic [CNT_W-1:0] warn_thr_q;
	logic             thr_sel;

	// Register 0 sits at byte address 0; paddr[2] selects beyond the list.
	assign thr_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_thr_q <= WARN_RESET;
		end else if (psel && penable && pwrite && thr_sel) begin
			warn_thr_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = thr_sel ? {{(32-CNT_W){1'b0}}, warn_thr_q} : '0;

	fla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	fla_datapath #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.release_index  (release_index),
		.warn_threshold (warn_thr_q),
		.granted_index  (granted_index),
		.alloc_ok       (alloc_ok),
		.stop_warning   (stop_warning),
		.used_count     (used_count),
		.done           (done)
	);

endmodule

### src/fla_ctrl.sv
// Controller state machine of the free-list pool allocator.
// Depends on fla_pkg for the state type and the command and status structs.
module fla_ctrl
	import fla_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output fla_cmd_t cmd,
	input  fla_sts_t sts
);

	fla_state_t state_q;
	fla_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: clearing pass, then an execute state for each accepted item.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.init_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	// Outputs decoded from the current state and, for capture, from start.
	always_comb begin
		busy        = (state_q != ST_IDLE);
		cmd.init_wr = (state_q == ST_INIT);
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.exec    = (state_q == ST_EXEC);
	end

endmodule

### src/fla_datapath.sv
// Datapath of the free-list pool allocator: link memory, head and empty
// state, the used counter and the result registers.
// Depends on fla_pkg; driven by fla_ctrl through fla_cmd_t.
module fla_datapath
	import fla_pkg::*;
#(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fla_cmd_t         cmd,
	output fla_sts_t         sts,
	input  logic             kind,
	input  logic [IDX_W-1:0] release_index,
	input  logic [CNT_W-1:0] warn_threshold,
	output logic [IDX_W-1:0] granted_index,
	output logic             alloc_ok,
	output logic             stop_warning,
	output logic [CNT_W-1:0] used_count,
	output logic             done
);

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int CW = (IW > IDX_W) ? IW : IDX_W;

	// Link memory: bit IW marks a real successor, the low bits hold it.
	logic [IW:0] link_mem [POOL_DEPTH];
	logic [IW:0] link_rd_q;
	logic        mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW:0] mem_wdata;

	logic [IW-1:0] init_cnt_q;
	logic [IW-1:0] head_q;
	logic          empty_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	logic             kind_q;
	logic [IDX_W-1:0] rel_q;
	logic [CW-1:0]    rel_w;
	logic [IW-1:0]    rel_idx;
	logic             rel_in_range;
	logic             do_pop;
	logic             do_push;

	logic [IDX_W-1:0] granted_q;
	logic             ok_q;
	logic             warn_q;
	logic [CNT_W-1:0] used_q;
	logic             done_q;

	// Release index widened to the pool index and range checked.
	assign rel_w        = CW'(rel_q);
	assign rel_idx      = rel_w[IW-1:0];
	assign rel_in_range = ((CW+1)'(rel_w) < (CW+1)'(POOL_DEPTH));

	assign do_pop  = cmd.exec && (kind_q == KIND_ALLOC) && !empty_q;
	assign do_push = cmd.exec && (kind_q == KIND_RELEASE) && rel_in_range;

	assign sts.init_last = cmd.init_wr && (init_cnt_q == IW'(POOL_DEPTH - 1));

	// Memory write port: the clearing pass or a pushed entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = init_cnt_q;
		mem_wdata = {(init_cnt_q != '0), init_cnt_q - IW'(1)};
		if (cmd.init_wr) begin
			mem_we = 1'b1;
		end else if (do_push) begin
			mem_we    = 1'b1;
			mem_waddr = rel_idx;
			mem_wdata = {!empty_q, head_q};
		end
	end

	// Link memory with a registered read of the current head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		link_rd_q <= link_mem[head_q];
	end

	// Clearing pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (cmd.init_wr) begin
			init_cnt_q <= init_cnt_q + IW'(1);
		end
	end

	// Latch the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			rel_q  <= release_index;
		end
	end

	// Used count after the item, saturating at both ends.
	always_comb begin
		count_nxt = count_q;
		if (do_pop && (count_q != CNT_MAX)) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_push && (count_q != '0)) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Free list head, empty flag and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= IW'(POOL_DEPTH - 1);
			empty_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_pop) begin
				head_q  <= link_rd_q[IW-1:0];
				empty_q <= !link_rd_q[IW];
			end else if (do_push) begin
				head_q  <= rel_idx;
				empty_q <= 1'b0;
			end
			count_q <= count_nxt;
		end
	end

	// Result registers, loaded in the execute state and held until the next item.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted_q <= do_pop ? IDX_W'(CW'(head_q)) : '0;
			ok_q      <= (kind_q == KIND_RELEASE) || !empty_q;
			warn_q    <= (count_nxt > warn_threshold);
			used_q    <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	assign granted_index = granted_q;
	assign alloc_ok      = ok_q;
	assign stop_warning  = warn_q;
	assign used_count    = used_q;
	assign done          = done_q;

`ifndef SYNTHESIS
	// Every execute cycle yields exactly one result strobe.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done_q)
		else $error("result strobe missing after execute");

	// A failed allocation only happens on an empty list and grants zero.
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ok_q) |-> (empty_q && (granted_q == '0)))
		else $error("failed allocation with entries free");

	// A valid release makes the released entry the new, non-empty head.
	a_push_head: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (!empty_q && (head_q == $past(rel_idx))))
		else $error("release did not become head");

	// Items are never executed during the clearing pass.
	a_no_exec_init: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.init_wr && (cmd.exec || cmd.capture)))
		else $error("item handled during clearing pass");
`endif

endmodule
